// ===== rtl/bale_pkg.sv =====
// ----------------------------------------------------------------------------
// bale_pkg
// Shared types and codes for the bounded array list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package bale_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 5;

  typedef enum logic [1:0] {
    CMD_PUSH_BACK   = 2'd0,
    CMD_PUSH_FRONT  = 2'd1,
    CMD_ERASE_VALUE = 2'd2,
    CMD_ERASE_FRONT = 2'd3
  } command_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_e;

  typedef struct packed {
    command_e                   command;
    logic signed [ValueW-1:0]   value;
  } cmd_t;

  typedef struct packed {
    status_e             status;
    logic [CountW-1:0]   count;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/bale_mem.sv =====
// ----------------------------------------------------------------------------
// bale_mem
// Entry storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bale_mem
  import bale_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AW-1:0]     waddr_i,
  input  wire logic [ValueW-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [AW-1:0]     raddr_i,
  output logic      [ValueW-1:0] rdata_o
);

  logic [ValueW-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bounded_array_list_engine.sv =====
// ----------------------------------------------------------------------------
// bounded_array_list_engine
// Packed list of signed 32-bit values with push at both ends, erase at the front and erase by value.
// ----------------------------------------------------------------------------
// The list lives in a circular buffer in one memory with a head pointer, so
// for push back, push front and erase front busy stays low: a new item may be
// started every cycle and the result strobes on done_o the cycle after the
// item is taken. Erase value walks the list through the one read port,
// reading one entry a cycle and writing each entry after the match one place
// down as it passes, with busy high until the walk is done; on an empty list
// it returns the empty status without raising busy. Results cannot be held
// off: done_o is high for a single cycle per result.
`default_nettype none

module bounded_array_list_engine
  import bale_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  input  wire cmd_t cmd_i,
  output logic      busy,
  output logic      done_o,
  output res_t      res_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  state_e                   state_q, state_d;
  logic [AW-1:0]            head_q, head_d;
  logic [CW-1:0]            count_q, count_d;
  logic [CW-1:0]            issue_q, issue_d;
  logic                     rd_vld_q, rd_vld_d;
  logic [AW-1:0]            rd_pos_q, rd_pos_d;
  logic                     found_q, found_d;
  logic                     done_q, done_d;
  logic signed [ValueW-1:0] val_q, val_d;
  res_t                     res_q, res_d;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [ValueW-1:0] mem_wdata, mem_rdata;

  logic full, empty, last, hit;

  // logical position to physical address, sum stays below twice DEPTH
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [AW-1:0] pos);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, pos};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign full  = (count_q == CW'(DEPTH));
  assign empty = (count_q == '0);
  assign last  = rd_vld_q && (CW'(rd_pos_q) == (count_q - CW'(1)));
  assign hit   = rd_vld_q && !found_q && (mem_rdata == val_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start && (cmd_i.command == CMD_ERASE_VALUE) && !empty) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    head_d    = head_q;
    count_d   = count_q;
    issue_d   = issue_q;
    rd_vld_d  = 1'b0;
    rd_pos_d  = rd_pos_q;
    found_d   = found_q;
    val_d     = val_q;
    done_d    = 1'b0;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          done_d = 1'b1;
          res_d  = '{status: STAT_OK, count: CountW'(count_q)};
          case (cmd_i.command)
            CMD_PUSH_BACK: begin
              if (full) begin
                res_d.status = STAT_FULL;
              end else begin
                mem_we      = 1'b1;
                mem_waddr   = phys(head_q, count_q[AW-1:0]);
                mem_wdata   = cmd_i.value;
                count_d     = count_q + CW'(1);
                res_d.count = CountW'(count_q + CW'(1));
              end
            end
            CMD_PUSH_FRONT: begin
              if (full) begin
                res_d.status = STAT_FULL;
              end else begin
                head_d      = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
                mem_we      = 1'b1;
                mem_waddr   = head_d;
                mem_wdata   = cmd_i.value;
                count_d     = count_q + CW'(1);
                res_d.count = CountW'(count_q + CW'(1));
              end
            end
            CMD_ERASE_VALUE: begin
              if (empty) begin
                res_d.status = STAT_EMPTY;
              end else begin
                done_d  = 1'b0;
                val_d   = cmd_i.value;
                issue_d = '0;
                found_d = 1'b0;
              end
            end
            CMD_ERASE_FRONT: begin
              if (empty) begin
                res_d.status = STAT_EMPTY;
              end else begin
                head_d      = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
                count_d     = count_q - CW'(1);
                res_d.count = CountW'(count_q - CW'(1));
              end
            end
            default: begin
              res_d.status = STAT_OK;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (issue_q < count_q) begin
          mem_re    = 1'b1;
          mem_raddr = phys(head_q, issue_q[AW-1:0]);
          issue_d   = issue_q + CW'(1);
          rd_vld_d  = 1'b1;
          rd_pos_d  = issue_q[AW-1:0];
        end
        if (rd_vld_q) begin
          if (found_q) begin
            // close the gap: entry moves one place toward the head
            mem_we    = 1'b1;
            mem_waddr = phys(head_q, rd_pos_q - AW'(1));
            mem_wdata = mem_rdata;
          end else if (hit) begin
            found_d = 1'b1;
          end
        end
        if (last) begin
          done_d = 1'b1;
          if (found_q || hit) begin
            count_d = count_q - CW'(1);
            res_d   = '{status: STAT_OK, count: CountW'(count_q - CW'(1))};
          end else begin
            res_d   = '{status: STAT_NOT_FOUND, count: CountW'(count_q)};
          end
        end
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      head_q   <= '0;
      count_q  <= '0;
      issue_q  <= '0;
      rd_vld_q <= 1'b0;
      rd_pos_q <= '0;
      found_q  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      count_q  <= count_d;
      issue_q  <= issue_d;
      rd_vld_q <= rd_vld_d;
      rd_pos_q <= rd_pos_d;
      found_q  <= found_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    res_q <= res_d;
  end

  bale_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign busy   = (state_q == ST_SCAN);
  assign done_o = done_q;
  assign res_o  = res_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("fill count above capacity");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while scan still running");

  a_quick_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (cmd_i.command != CMD_ERASE_VALUE)) |=> done_o)
    else $error("single-cycle command gave no result");

  a_shift_after_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && mem_we) |-> found_q)
    else $error("entry moved before a match was found");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (res_o.status == STAT_FULL)) |-> (res_o.count == CountW'(DEPTH)))
    else $error("full status with list not full");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bounded array list engine. A class keeps a
// mirror of the list and queues the status and count that each accepted
// command should return. Directed commands cover the empty, full and
// not-found cases, then random commands swing the list between empty and
// full under bursty start traffic.
// ----------------------------------------------------------------------------

import bale_pkg::*;

module tb;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned RandomItems = 400;

  class list_tracker;
    logic signed [ValueW-1:0] entries [DEPTH];
    int unsigned              fill;
    res_t                     pending_results [$];
    int unsigned              mismatches;

    function new();
      fill       = 0;
      mismatches = 0;
    endfunction

    // close the gap at pos and drop one entry
    function void remove_at(int unsigned pos);
      int unsigned i;
      for (i = pos; i + 1 < fill; i++) begin
        entries[i] = entries[i + 1];
      end
      fill--;
    endfunction

    function void record_command(cmd_t c);
      res_t        r;
      int unsigned i;
      int unsigned hit;
      r.status = STAT_OK;
      case (c.command)
        CMD_PUSH_BACK: begin
          if (fill >= DEPTH) begin
            r.status = STAT_FULL;
          end else begin
            entries[fill] = c.value;
            fill++;
          end
        end
        CMD_PUSH_FRONT: begin
          if (fill >= DEPTH) begin
            r.status = STAT_FULL;
          end else begin
            for (i = fill; i > 0; i--) begin
              entries[i] = entries[i - 1];
            end
            entries[0] = c.value;
            fill++;
          end
        end
        CMD_ERASE_VALUE: begin
          if (fill == 0) begin
            r.status = STAT_EMPTY;
          end else begin
            hit = fill;
            for (i = 0; i < fill; i++) begin
              if (entries[i] == c.value) begin
                hit = i;
                break;
              end
            end
            if (hit == fill) begin
              r.status = STAT_NOT_FOUND;
            end else begin
              remove_at(hit);
            end
          end
        end
        default: begin
          if (fill == 0) begin
            r.status = STAT_EMPTY;
          end else begin
            remove_at(0);
          end
        end
      endcase
      r.count = fill[CountW-1:0];
      pending_results.push_back(r);
    endfunction

    function void compare_result(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: status %0d count %0d", got.status, got.count);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status) begin
        $error("status mismatch: expected %0d actual %0d", want.status, got.status);
        mismatches++;
      end
      if (got.count !== want.count) begin
        $error("count mismatch: expected %0d actual %0d", want.count, got.count);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  cmd_t cmd_i;
  logic busy;
  logic done_o;
  res_t res_o;

  list_tracker tracker = new();

  bounded_array_list_engine #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .cmd_i (cmd_i),
    .busy  (busy),
    .done_o(done_o),
    .res_o (res_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      tracker.compare_result(res_o);
    end
  end

  // present one command and hold it until the engine takes it
  task automatic send_command(input command_e op, input logic signed [ValueW-1:0] val);
    @(negedge clk_i);
    start <= 1'b1;
    cmd_i <= '{command: op, value: val};
    do @(posedge clk_i); while (busy !== 1'b0);
    tracker.record_command(cmd_i);
  endtask

  task automatic idle_cycles(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  task automatic wait_for_drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [ValueW-1:0] any_value();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 6) - 3;
      1: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic                     filling;
    logic                     paused;
    int unsigned              sent;
    int unsigned              burst;
    int unsigned              guard;
    command_e                 op;
    logic signed [ValueW-1:0] val;

    rst_ni = 1'b0;
    start  = 1'b0;
    cmd_i  = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // erases on an empty list
    send_command(CMD_ERASE_VALUE, 32'sd5);
    send_command(CMD_ERASE_FRONT, 32'sd0);
    send_command(CMD_PUSH_BACK, 32'sh8000_0000);
    send_command(CMD_PUSH_BACK, 32'sh7fff_ffff);
    send_command(CMD_PUSH_BACK, 32'sd0);
    idle_cycles(2);
    send_command(CMD_PUSH_BACK, -32'sd1);
    // duplicate at the head: the first match must go
    send_command(CMD_PUSH_FRONT, 32'sh7fff_ffff);
    send_command(CMD_ERASE_VALUE, 32'sh7fff_ffff);
    send_command(CMD_ERASE_VALUE, 32'sd1234);
    send_command(CMD_ERASE_VALUE, -32'sd1);
    send_command(CMD_ERASE_FRONT, 32'sh5a5a_a5a5);
    send_command(CMD_PUSH_FRONT, 32'sh8000_0000);
    while (tracker.fill < DEPTH) begin
      if (tracker.fill[0]) begin
        send_command(CMD_PUSH_FRONT, $urandom);
      end else begin
        send_command(CMD_PUSH_BACK, $urandom);
      end
    end
    send_command(CMD_PUSH_BACK, 32'sd7);
    send_command(CMD_PUSH_FRONT, 32'sd7);
    send_command(CMD_ERASE_VALUE, tracker.entries[DEPTH - 1]);
    wait_for_drain();

    filling = 1'b0;
    paused  = 1'b0;
    sent    = 0;
    while (sent < RandomItems) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        if (tracker.fill >= DEPTH) begin
          filling = 1'b0;
        end else if (tracker.fill == 0) begin
          filling = 1'b1;
        end
        if ($urandom_range(0, 99) < (filling ? 75 : 25)) begin
          op  = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
          val = any_value();
        end else begin
          op = $urandom_range(0, 1) ? CMD_ERASE_VALUE : CMD_ERASE_FRONT;
          if (tracker.fill > 0 && $urandom_range(0, 3) != 0) begin
            val = tracker.entries[$urandom_range(0, tracker.fill - 1)];
          end else begin
            val = any_value();
          end
        end
        send_command(op, val);
        sent++;
      end
      if (!paused && sent >= RandomItems / 2) begin
        paused = 1'b1;
        wait_for_drain();
      end
      case ($urandom_range(0, 7))
        0, 1:    ;
        2:       idle_cycles($urandom_range(10, 40));
        default: idle_cycles($urandom_range(1, 6));
      endcase
    end

    @(negedge clk_i);
    start <= 1'b0;
    guard = 0;
    while (tracker.pending_results.size() != 0 && guard < 1000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (2 * DEPTH) @(posedge clk_i);
    if (tracker.pending_results.size() != 0) begin
      $error("%0d results never arrived", tracker.pending_results.size());
    end
    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

endmodule
